// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for the concurrent checks used by the block checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the next clock, switched off while reset is high
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// implication checked on the next clock, also live during reset
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/ssra_pkg.sv =====
// ----------------------------------------------------------------------------
// ssra_pkg
// shared widths, codes and control bundles of the sprite rectangle animator
// ----------------------------------------------------------------------------
package ssra_pkg;

   // field and register widths
   localparam int COORD_BITS     = 16;
   localparam int TIME_BITS      = 24;
   localparam int FIELD_BITS     = 16;
   localparam int RECT_BITS      = 64;
   localparam int PART_STRIDE    = 16;
   localparam int COUNT_BITS     = 8;
   localparam int PERIOD_BITS    = 16;
   localparam int FLAG_BITS      = 4;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int PART_COUNT     = 4;
   localparam int PART_IDX_BITS  = 2;

   // derived arithmetic widths
   localparam int FRAC_BITS   = 16;
   localparam int TOTAL_BITS  = COUNT_BITS + PERIOD_BITS;
   localparam int WIDE_BITS   = (TIME_BITS > TOTAL_BITS) ? TIME_BITS : TOTAL_BITS;
   localparam int QUO_BITS    = FRAC_BITS;
   localparam int MUL_BITS_A  = (COORD_BITS + 2 > FRAC_BITS + 2) ? COORD_BITS + 2
                                                                   : FRAC_BITS + 2;
   localparam int MUL_BITS    = (MUL_BITS_A > PERIOD_BITS + 1) ? MUL_BITS_A
                                                                : PERIOD_BITS + 1;
   localparam int PROD_BITS   = 2 * MUL_BITS;
   localparam int NSUM_BITS   = PROD_BITS + 1;
   localparam int MAX_STEPS   = (TIME_BITS > FRAC_BITS) ? TIME_BITS : FRAC_BITS;
   localparam int STEP_BITS   = $clog2(MAX_STEPS + 1);

   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
   localparam logic [FRAC_BITS:0]   FRAC_FULL = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [NSUM_BITS-1:0] ROUND_BIAS = NSUM_BITS'({FRAC_BITS{1'b1}});

   // rectangle part positions
   localparam logic [PART_IDX_BITS-1:0] PART_WIDTH  = 2'd2;
   localparam logic [PART_IDX_BITS-1:0] PART_HEIGHT = 2'd3;

   // animation modes
   typedef enum logic [MODE_BITS-1:0] {
      MODE_FIXED = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_SWEEP = 2'd2
   } mode_type;

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE   = 3'd0,
      CSR_START  = 3'd1,
      CSR_END    = 3'd2,
      CSR_COUNT  = 3'd3,
      CSR_PERIOD = 3'd4,
      CSR_LOOPED = 3'd5,
      CSR_FLAGS  = 3'd6
   } csr_index_type;

   // divider command and status
   typedef struct packed {
      logic                   start;
      logic [TOTAL_BITS-1:0]  rem_init;
      logic [TIME_BITS-1:0]   dividend;
      logic [TOTAL_BITS-1:0]  divisor;
      logic [STEP_BITS-1:0]   steps;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [QUO_BITS-1:0]    quotient;
   } div_rsp_type;

   // one coordinate of a packed rectangle
   function automatic logic [COORD_BITS-1:0] rect_part(
      input logic [RECT_BITS-1:0]     rect,
      input logic [PART_IDX_BITS-1:0] sel
   );
      return rect[sel * PART_STRIDE +: COORD_BITS];
   endfunction

endpackage

// ===== hdl/ssra_div.sv =====
// ----------------------------------------------------------------------------
// ssra_div
// restoring divider, one quotient bit per clock, reused for frame and fraction
// ----------------------------------------------------------------------------
module ssra_div
   import ssra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type div_cmd,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0]  dvd_ff, dvd_in;
   logic [TOTAL_BITS-1:0] dsr_ff, dsr_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;

   logic [TOTAL_BITS:0]   rem_shift;
   logic [TOTAL_BITS:0]   rem_diff;
   logic                  fits;

   // shared subtract and compare
   assign rem_shift = {rem_ff, dvd_ff[TIME_BITS-1]};
   assign fits      = rem_shift >= (TOTAL_BITS+1)'(dsr_ff);
   assign rem_diff  = rem_shift - (TOTAL_BITS+1)'(dsr_ff);

   // next step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         rem_in  = div_cmd.rem_init;
         dvd_in  = div_cmd.dividend;
         dsr_in  = div_cmd.divisor;
         quo_in  = '0;
         cnt_in  = div_cmd.steps;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[TOTAL_BITS-1:0] : rem_shift[TOTAL_BITS-1:0];
         dvd_in = {dvd_ff[TIME_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hdl/ssra_mul.sv =====
// ----------------------------------------------------------------------------
// ssra_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module ssra_mul
   import ssra_pkg::*;
(
   input  logic                        clock,
   input  logic                        mul_go,
   input  logic signed [MUL_BITS-1:0]  mul_a,
   input  logic signed [MUL_BITS-1:0]  mul_b,
   output logic signed [PROD_BITS-1:0] mul_product
);

   logic signed [PROD_BITS-1:0] product_ff, product_in;

   // product captured only when a multiply is issued
   always_comb begin
      product_in = product_ff;
      if (mul_go) begin
         product_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign mul_product = product_ff;

endmodule

// ===== hdl/sprite_source_rect_animator.sv =====
// ----------------------------------------------------------------------------
// sprite_source_rect_animator
// source rectangle animator: time accumulator, frame stepping and sweep
// ----------------------------------------------------------------------------
// Usage: each req_ transaction is one tick carrying the elapsed time. The
// block answers every tick with exactly one rsp_ transaction holding the
// source rectangle (x, y, width, height). The user must write registers
// through the csr_ port only while no tick is in flight; the block does
// not enforce this. Any write to a valid index clears the time accumulator.
// Path from tick acceptance to rsp_valid: fixed mode and animations too
// short to step go straight to the output; the others first multiply
// frame count by period, then tick mode wraps, clamps or divides (frame =
// time / period) and sweep mode clamps at or past its end or divides for
// a fraction on the one-bit-per-clock divider, followed by four multiply
// and add passes on the single shared multiplier.
// One tick is in flight at a time; req_ready is high only while idle.
// The result sits in an output register, so a new tick is accepted while
// the previous result waits; a stalled receiver holds the finished result
// there and the sequencer waits before overwriting it.
// Reset clears the accumulator, loads the register reset values and drops
// rsp_valid.
// ----------------------------------------------------------------------------
module sprite_source_rect_animator
   import ssra_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // tick input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [FIELD_BITS-1:0]         req_elapsed,
   // rectangle output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FIELD_BITS-1:0]  rsp_rect_x,
   output logic signed [FIELD_BITS-1:0]  rsp_rect_y,
   output logic [FIELD_BITS-1:0]         rsp_rect_width,
   output logic [FIELD_BITS-1:0]         rsp_rect_height,
   // register writes
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_FRAC,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [RECT_BITS-1:0]   start_ff, start_in;
   logic [RECT_BITS-1:0]   end_ff, end_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   looped_ff, looped_in;
   logic [FLAG_BITS-1:0]   flags_ff, flags_in;

   // working state
   logic [TIME_BITS-1:0]     acc_ff, acc_in;
   logic [TOTAL_BITS-1:0]    total_ff, total_in;
   logic [COUNT_BITS-1:0]    frame_ff, frame_in;
   logic [FRAC_BITS:0]       frac_ff, frac_in;
   logic [PART_IDX_BITS-1:0] idx_ff, idx_in;
   logic [COORD_BITS-1:0]    v_ff [PART_COUNT];
   logic [COORD_BITS-1:0]    v_in [PART_COUNT];

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]  rsp_x_ff, rsp_x_in;
   logic [FIELD_BITS-1:0]  rsp_y_ff, rsp_y_in;
   logic [FIELD_BITS-1:0]  rsp_w_ff, rsp_w_in;
   logic [FIELD_BITS-1:0]  rsp_h_ff, rsp_h_in;

   // shared units
   logic                        mul_go;
   logic signed [MUL_BITS-1:0]  mul_a;
   logic signed [MUL_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0] mul_product;
   div_cmd_type                 div_cmd;
   div_rsp_type                 div_rsp;

   // helpers
   logic [TIME_BITS:0]           acc_sum;
   logic [TIME_BITS-1:0]         acc_sat;
   logic [PERIOD_BITS-1:0]       period_eff;
   logic [TOTAL_BITS-1:0]        total_now;
   logic [WIDE_BITS-1:0]         acc_wide;
   logic [WIDE_BITS-1:0]         total_now_wide;
   logic [WIDE_BITS-1:0]         total_ff_wide;
   logic                         reached_now;
   logic                         reached_frac;
   logic [TIME_BITS-1:0]         total_sat;
   logic [COORD_BITS-1:0]        start_part;
   logic [COORD_BITS-1:0]        end_part;
   logic [COORD_BITS-1:0]        size_part;
   logic                         signed_part;
   logic signed [COORD_BITS:0]   s_ext;
   logic signed [COORD_BITS:0]   e_ext;
   logic signed [COORD_BITS+1:0] diff;
   logic signed [NSUM_BITS-1:0]  n_sum;
   logic signed [NSUM_BITS-1:0]  n_adj;
   logic signed [NSUM_BITS-1:0]  n_quot;
   logic [COORD_BITS-1:0]        sweep_part;
   logic [COORD_BITS-1:0]        tick_part;

   ssra_mul u_mul (
      .clock       (clock),
      .mul_go      (mul_go),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_product (mul_product)
   );

   ssra_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   // saturating time accumulation
   assign acc_sum    = {1'b0, acc_ff} + (TIME_BITS+1)'(req_elapsed);
   assign acc_sat    = acc_sum[TIME_BITS] ? TIME_MAX : acc_sum[TIME_BITS-1:0];
   assign period_eff = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;

   // end of animation checks
   assign total_now      = mul_product[TOTAL_BITS-1:0];
   assign acc_wide       = WIDE_BITS'(acc_ff);
   assign total_now_wide = WIDE_BITS'(total_now);
   assign total_ff_wide  = WIDE_BITS'(total_ff);
   assign reached_now    = acc_wide >= total_now_wide;
   assign reached_frac   = acc_wide >= total_ff_wide;
   assign total_sat      = (total_now_wide > WIDE_BITS'(TIME_MAX))
                           ? TIME_MAX : total_now_wide[TIME_BITS-1:0];

   // current rectangle part; x and y are signed, sizes unsigned
   assign start_part  = rect_part(start_ff, idx_ff);
   assign end_part    = rect_part(end_ff, idx_ff);
   assign size_part   = rect_part(start_ff, idx_ff[0] ? PART_HEIGHT : PART_WIDTH);
   assign signed_part = ~idx_ff[1];
   assign s_ext       = {signed_part & start_part[COORD_BITS-1], start_part};
   assign e_ext       = {signed_part & end_part[COORD_BITS-1], end_part};
   assign diff        = (COORD_BITS+2)'(e_ext) - (COORD_BITS+2)'(s_ext);

   // sweep: (s << 16) + (e - s) * f, truncated toward zero
   assign n_sum      = (NSUM_BITS'(s_ext) <<< FRAC_BITS) + NSUM_BITS'(mul_product);
   assign n_adj      = n_sum[NSUM_BITS-1] ? (n_sum + ROUND_BIAS) : n_sum;
   assign n_quot     = n_adj >>> FRAC_BITS;
   assign sweep_part = n_quot[COORD_BITS-1:0];

   // tick: start plus size times frame where the flag is set
   assign tick_part = flags_ff[idx_ff] ? (start_part + mul_product[COORD_BITS-1:0])
                                       : start_part;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      period_in    = period_ff;
      looped_in    = looped_ff;
      flags_in     = flags_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      frame_in     = frame_ff;
      frac_in      = frac_ff;
      idx_in       = idx_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_h_in     = rsp_h_ff;
      mul_go       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_cmd      = '0;

      // result taken by the receiver
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in = acc_sat;
               idx_in = '0;
               for (int i = 0; i < PART_COUNT; i++) begin
                  v_in[i] = rect_part(start_ff, PART_IDX_BITS'(i));
               end
               if ((mode_ff == MODE_TICK && count_ff > COUNT_BITS'(1)) ||
                   (mode_ff == MODE_SWEEP && count_ff != '0)) begin
                  // animation length = frame count times period
                  mul_go   = 1'b1;
                  mul_a    = MUL_BITS'(count_ff);
                  mul_b    = MUL_BITS'(period_eff);
                  state_in = ST_TOTAL;
               end else begin
                  if (mode_ff != MODE_TICK && mode_ff != MODE_SWEEP) begin
                     acc_in = '0;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_TOTAL: begin
            total_in = total_now;
            if (reached_now) begin
               acc_in = looped_ff ? (acc_ff - total_now_wide[TIME_BITS-1:0]) : total_sat;
            end
            if (mode_ff == MODE_TICK) begin
               if (reached_now) begin
                  frame_in = looped_ff ? '0 : count_ff;
                  state_in = ST_MUL;
               end else begin
                  // frame = time / period
                  div_cmd.start    = 1'b1;
                  div_cmd.rem_init = '0;
                  div_cmd.dividend = acc_ff;
                  div_cmd.divisor  = TOTAL_BITS'(period_eff);
                  div_cmd.steps    = STEP_BITS'(TIME_BITS);
                  state_in         = ST_DIV;
               end
            end else begin
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (reached_frac) begin
               frac_in  = FRAC_FULL;
               state_in = ST_MUL;
            end else begin
               // fraction = time * 2^16 / total
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = acc_wide[TOTAL_BITS-1:0];
               div_cmd.dividend = '0;
               div_cmd.divisor  = total_ff;
               div_cmd.steps    = STEP_BITS'(FRAC_BITS);
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (mode_ff == MODE_TICK) begin
                  frame_in = div_rsp.quotient[COUNT_BITS-1:0];
               end else begin
                  frac_in = {1'b0, div_rsp.quotient};
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_go = 1'b1;
            if (mode_ff == MODE_TICK) begin
               mul_a = MUL_BITS'(size_part);
               mul_b = MUL_BITS'(frame_ff);
            end else begin
               mul_a = MUL_BITS'(diff);
               mul_b = MUL_BITS'(frac_ff);
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            v_in[idx_ff] = (mode_ff == MODE_TICK) ? tick_part : sweep_part;
            if (idx_ff == PART_IDX_BITS'(PART_COUNT - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + PART_IDX_BITS'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = FIELD_BITS'(signed'(v_ff[0]));
               rsp_y_in     = FIELD_BITS'(signed'(v_ff[1]));
               rsp_w_in     = FIELD_BITS'(v_ff[2]);
               rsp_h_in     = FIELD_BITS'(v_ff[3]);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes, each clears the accumulator
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[MODE_BITS-1:0];
               acc_in  = '0;
            end
            CSR_START: begin
               start_in = csr_wdata[RECT_BITS-1:0];
               acc_in   = '0;
            end
            CSR_END: begin
               end_in = csr_wdata[RECT_BITS-1:0];
               acc_in = '0;
            end
            CSR_COUNT: begin
               count_in = csr_wdata[COUNT_BITS-1:0];
               acc_in   = '0;
            end
            CSR_PERIOD: begin
               period_in = csr_wdata[PERIOD_BITS-1:0];
               acc_in    = '0;
            end
            CSR_LOOPED: begin
               looped_in = csr_wdata[0];
               acc_in    = '0;
            end
            CSR_FLAGS: begin
               flags_in = csr_wdata[FLAG_BITS-1:0];
               acc_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         count_ff     <= '0;
         period_ff    <= PERIOD_BITS'(1);
         looped_ff    <= 1'b0;
         flags_ff     <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         looped_ff    <= looped_in;
         flags_ff     <= flags_in;
         acc_ff       <= acc_in;
      end
      total_ff <= total_in;
      frame_ff <= frame_in;
      frac_ff  <= frac_in;
      idx_ff   <= idx_in;
      v_ff     <= v_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_w_ff <= rsp_w_in;
      rsp_h_ff <= rsp_h_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_x      = rsp_x_ff;
   assign rsp_rect_y      = rsp_y_ff;
   assign rsp_rect_width  = rsp_w_ff;
   assign rsp_rect_height = rsp_h_ff;

endmodule

// ===== hdl/ssra_checker.sv =====
// ----------------------------------------------------------------------------
// ssra_checker
// port-level checks of the sprite rectangle animator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssra_checker
   import ssra_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [FIELD_BITS-1:0] rsp_rect_x,
   input logic signed [FIELD_BITS-1:0] rsp_rect_y,
   input logic [FIELD_BITS-1:0]        rsp_rect_width,
   input logic [FIELD_BITS-1:0]        rsp_rect_height
);

   // no result straight out of reset
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "rsp_valid after reset")

   // one tick in flight: the input closes after each transaction
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "req_ready held after accept")

   // an accepted tick never raises rsp_valid at once
   `ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result too early")

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rect_x) && $stable(rsp_rect_y) && $stable(rsp_rect_width) && $stable(rsp_rect_height), "stalled result changed")

endmodule

bind sprite_source_rect_animator ssra_checker u_ssra_checker (.*);
